/* rtl/core/lwma_pkg.sv */
// shared types and constants of the linear weighted moving average block
package lwma_pkg;

  localparam int CFG_WIDTH = 5;
  localparam int OUT_WIDTH = 24;
  localparam int WIN_MIN   = 2;
  localparam int WIN_RESET = 5;
  localparam int FRAC_BITS = 8;

  localparam logic OP_FILTER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MAC,
    S_PREP,
    S_DIV,
    S_DONE
  } lwma_state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic addr_step;
    logic mac;
    logic prep;
    logic div_step;
    logic emit;
  } lwma_cmd_t;

  typedef struct packed {
    logic mac_last;
    logic div_last;
    logic out_free;
  } lwma_status_t;

endpackage

/* rtl/core/lwma_ctrl.sv */
// controller state machine of the linear weighted moving average block
module lwma_ctrl import lwma_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic         operation,
  input  lwma_status_t status,
  output lwma_cmd_t    cmd
);

  lwma_state_t state;
  lwma_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (operation == OP_CLEAR) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.load   = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.addr_step = 1'b1;
        state_next    = S_MAC;
      end
      S_MAC: begin
        cmd.mac       = 1'b1;
        cmd.addr_step = 1'b1;
        if (status.mac_last) begin
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/lwma_dp.sv */
// datapath: sample ring, multiply-accumulate, serial divider and output register
module lwma_dp import lwma_pkg::*; #(
  parameter int MAX_WINDOW   = 20,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_enable,
  input  logic [CFG_WIDTH-1:0]           cfg_write_data,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  lwma_cmd_t                      cmd,
  output lwma_status_t                   status,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [OUT_WIDTH-1:0]    average
);

  localparam int CW     = $clog2(MAX_WINDOW + 1);
  localparam int AW     = $clog2(MAX_WINDOW);
  localparam int TSUM   = MAX_WINDOW * (MAX_WINDOW + 1) / 2;
  localparam int TW     = $clog2(TSUM + 1);
  localparam int DW     = $clog2(2 * TSUM + 1);
  localparam int SUMW   = SAMPLE_WIDTH + TW + 1;
  localparam int NW     = SUMW + FRAC_BITS + 2;
  localparam int QW     = SAMPLE_WIDTH + FRAC_BITS;
  localparam int QCW    = $clog2(QW);
  localparam int EXTW   = QW + 1 + OUT_WIDTH;
  localparam int WIN_RST = (WIN_RESET > MAX_WINDOW) ? MAX_WINDOW : WIN_RESET;

  logic signed [SAMPLE_WIDTH-1:0] ring [MAX_WINDOW];
  logic signed [SAMPLE_WIDTH-1:0] rd_data;
  logic [AW-1:0]                  rd_addr;
  logic [AW-1:0]                  pos;
  logic [CW-1:0]                  fill;
  logic [CW-1:0]                  window;
  logic [CW-1:0]                  weight;
  logic signed [SUMW-1:0]         acc;
  logic [DW-1:0]                  den;
  logic [DW-1:0]                  rem;
  logic [QW-1:0]                  quo;
  logic [QCW-1:0]                 div_cnt;
  logic                           neg;

  logic [CW-1:0]                  fill_inc;
  logic [AW-1:0]                  pos_inc;
  logic [AW-1:0]                  addr_prev;
  logic signed [SUMW-1:0]         prod;
  logic [DW-1:0]                  den_c;
  logic signed [NW-1:0]           num_c;
  logic [NW-1:0]                  mag_c;
  logic [DW:0]                    trial;
  logic                           ge;
  logic signed [QW:0]             q_signed;
  logic signed [EXTW-1:0]         q_ext;

  assign fill_inc  = (fill == window) ? fill : fill + 1'b1;
  assign pos_inc   = (CW'(pos) + 1'b1 == window) ? '0 : pos + 1'b1;
  assign addr_prev = (rd_addr == '0) ? AW'(window - 1'b1) : rd_addr - 1'b1;
  assign prod      = SUMW'(rd_data * $signed({1'b0, weight}));
  assign den_c     = DW'(DW'(fill) * (DW'(fill) + 1'b1));
  assign num_c     = (NW'(acc) <<< (FRAC_BITS + 1)) + $signed(NW'(den_c >> 1));
  assign mag_c     = num_c[NW-1] ? ~num_c : num_c;
  assign trial     = {rem, quo[QW-1]};
  assign ge        = (trial >= {1'b0, den});
  assign q_signed  = neg ? ~$signed({1'b0, quo}) : $signed({1'b0, quo});
  assign q_ext     = EXTW'(q_signed);

  assign status.mac_last = (weight == CW'(1));
  assign status.div_last = (div_cnt == '0);
  assign status.out_free = !out_valid || !out_stall;

  // sample ring with registered read
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ring[pos] <= sample;
    end
    rd_data <= ring[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window <= CW'(WIN_RST);
      pos    <= '0;
      fill   <= '0;
    end else if (cfg_write_enable) begin
      if (cfg_write_data < CFG_WIDTH'(WIN_MIN)) begin
        window <= CW'(WIN_MIN);
      end else if (32'(cfg_write_data) > MAX_WINDOW) begin
        window <= CW'(MAX_WINDOW);
      end else begin
        window <= CW'(cfg_write_data);
      end
      pos  <= '0;
      fill <= '0;
    end else if (cmd.clear) begin
      pos  <= '0;
      fill <= '0;
    end else if (cmd.load) begin
      pos  <= pos_inc;
      fill <= fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_addr <= pos;
      weight  <= fill_inc;
      acc     <= '0;
    end else begin
      if (cmd.addr_step) begin
        rd_addr <= addr_prev;
      end
      if (cmd.mac) begin
        acc    <= acc + prod;
        weight <= weight - 1'b1;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      den     <= den_c;
      neg     <= num_c[NW-1];
      rem     <= mag_c[QW +: DW];
      quo     <= mag_c[QW-1:0];
      div_cnt <= QCW'(QW - 1);
    end else if (cmd.div_step) begin
      rem     <= ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      quo     <= {quo[QW-2:0], ge};
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      average <= q_ext[OUT_WIDTH-1:0];
    end
  end

endmodule

/* rtl/core/linear_weighted_moving_average.sv */
// top level of the linear weighted moving average filter
//
// input channel: in_valid / in_stall with operation and sample. operation
// filter stores the sample and yields one average; operation clear empties
// the ring and yields nothing. output channel: out_valid / out_stall with
// average, signed with 8 fraction bits, rounded half up.
// configuration: cfg_write_enable writes window_size (clamped to
// 2..MAX_WINDOW) and empties the ring; write only while the block is idle.
// a filter transaction, once accepted, passes the states read, mac, prep,
// div and done: the multiply-accumulate walk over the ring memory takes one
// sample per cycle over fill samples, fill being the number of stored
// samples (at most the window), and the restoring divider yields one
// quotient bit per cycle; done holds until the output register is free.
// one transaction is in work at a time, and a new one is taken only back in
// idle; a clear is done in the idle state and does not leave it.
// reset: window 5, ring empty, no result pending.
// a stalled result holds in the output register; the next transaction is
// still taken and waits at its end until the register is free.
module linear_weighted_moving_average import lwma_pkg::*; #(
  parameter int MAX_WINDOW   = 20,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_enable,
  input  logic [CFG_WIDTH-1:0]           cfg_write_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           operation,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [OUT_WIDTH-1:0]    average
);

  lwma_cmd_t    cmd;
  lwma_status_t status;

  lwma_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .status    (status),
    .cmd       (cmd)
  );

  lwma_dp #(
    .MAX_WINDOW   (MAX_WINDOW),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .sample           (sample),
    .cmd              (cmd),
    .status           (status),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .average          (average)
  );

endmodule
